### sv/assert_macros.svh
// Assertion macros used by the checker file of the sleep queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define SWQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge.
`define SWQ_ASSERT_NEVER(lbl, expr, msg) \
  `SWQ_ASSERT(lbl, !(expr), msg)

`endif

### sv/swq_pkg.sv
// Types and constants shared by the sleep queue modules.
package swq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int OCC_W           = 5;
  localparam int WAKE_W          = 32;
  localparam int PRIO_W          = 8;
  localparam int TASK_W          = 8;
  localparam int KEY_W           = WAKE_W + PRIO_W;

  typedef enum logic [1:0] {
    OP_POLL    = 2'd0,
    OP_ADD     = 2'd1,
    OP_REMOVE  = 2'd2,
    OP_REQUEUE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_NOTHING_DUE = 3'd0,
    ST_WOKEN       = 3'd1,
    ST_QUEUED      = 3'd2,
    ST_REMOVED     = 3'd3,
    ST_FULL        = 3'd4,
    ST_NOT_FOUND   = 3'd5
  } status_e;

  typedef struct packed {
    op_e                op;
    logic [TASK_W-1:0]  task_id;
    logic [WAKE_W-1:0]  delay;
    logic [PRIO_W-1:0]  priority_req;
    logic [WAKE_W-1:0]  now;
    logic [WAKE_W-1:0]  wake_tick;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [TASK_W-1:0]  out_task;
    logic [WAKE_W-1:0]  out_wake_tick;
    logic [OCC_W-1:0]   occupancy;
  } rsp_t;

  typedef struct packed {
    logic [WAKE_W-1:0]  wake;
    logic [TASK_W-1:0]  task_id;
    logic [PRIO_W-1:0]  prio;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

### sv/sleep_wake_queue.sv
// Top level of the sleep queue: sequencer, entry RAM and shared comparator.
//
// Usage: drive req_i and raise start_i; the transaction is taken at a rising
// edge with start_i high and busy_o low. busy_o stays high while the entry
// RAM is searched or shifted. Exactly one result follows each transaction: it
// sits on rsp_o for one cycle with valid_o high and cannot be held off, so the
// receiver must take it in that cycle. A new transaction may start in the same
// cycle as the result is shown.
// A poll of an empty queue, and an add or requeue to a full queue, are answered
// from the idle state without reading the RAM; a poll whose head is not yet due
// reads and tests only the head. Otherwise the search reads and tests entries in
// turn, and entries are then moved one at a time, each read and then written, as
// the RAM has one read and one write port and its read data is registered. A
// requeue does no search and puts its task at the head of the queue.
// The block takes one transaction at a time.
// Reset clears the task count and the sequencer; the entry RAM is not
// cleared, as only entries below the count are ever read.
module sleep_wake_queue #(
  parameter int QUEUE_DEPTH = swq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  swq_pkg::req_t req_i,
  output logic          busy_o,
  output logic          valid_o,
  output swq_pkg::rsp_t rsp_o
);

  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W = $clog2(QUEUE_DEPTH);
  localparam int KW     = swq_pkg::KEY_W;
  localparam int PW     = swq_pkg::PRIO_W;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_SCAN_RD  = 7'b0000010,
    S_SCAN_EV  = 7'b0000100,
    S_OPEN_RD  = 7'b0001000,
    S_OPEN_WR  = 7'b0010000,
    S_CLOSE_RD = 7'b0100000,
    S_CLOSE_WR = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] pos_q, pos_d;
  swq_pkg::op_e op_q, op_d;
  logic [KW-1:0] key_q, key_d;
  logic [swq_pkg::TASK_W-1:0] task_q, task_d;
  logic [swq_pkg::TASK_W-1:0] woke_task_q, woke_task_d;
  logic [swq_pkg::WAKE_W-1:0] woke_wake_q, woke_wake_d;
  swq_pkg::status_e status_q, status_d;
  logic valid_q, valid_d;

  logic ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  swq_pkg::entry_t ram_wdata, rd_entry;
  logic [swq_pkg::ENTRY_W-1:0] ram_rdata;

  logic [KW-1:0] cmp_a;
  logic cmp_gt, cmp_eq;

  logic [swq_pkg::WAKE_W-1:0] add_wake;
  logic [CNT_W-1:0] idx_inc, idx_dec;
  logic is_full;
  logic [CNT_W+swq_pkg::OCC_W-1:0] occ_ext;

  assign rd_entry = swq_pkg::entry_t'(ram_rdata);
  assign add_wake = req_i.now + req_i.delay;
  assign idx_inc  = idx_q + CNT_W'(1);
  assign idx_dec  = idx_q - CNT_W'(1);
  assign is_full  = (count_q == CNT_W'(QUEUE_DEPTH));

  // A remove compares task identifiers; every other search compares keys.
  assign cmp_a = (op_q == swq_pkg::OP_REMOVE) ?
                 {{(KW - swq_pkg::TASK_W){1'b0}}, rd_entry.task_id} :
                 {rd_entry.wake, rd_entry.prio};

  swq_ram #(
    .WIDTH(swq_pkg::ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  swq_cmp u_cmp (
    .a_i (cmp_a),
    .b_i (key_q),
    .gt_o(cmp_gt),
    .eq_o(cmp_eq)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    op_d        = op_q;
    key_d       = key_q;
    task_d      = task_q;
    woke_task_d = woke_task_q;
    woke_wake_d = woke_wake_q;
    status_d    = status_q;
    valid_d     = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = idx_q[ADDR_W-1:0];
    ram_wdata   = rd_entry;
    ram_raddr   = idx_q[ADDR_W-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d   = req_i.op;
          task_d = req_i.task_id;
          idx_d  = '0;
          unique case (req_i.op)
            swq_pkg::OP_POLL: begin
              // The low byte of all ones makes the key test a plain now >= wake.
              key_d = {req_i.now, {PW{1'b1}}};
              if (count_q == '0) begin
                valid_d  = 1'b1;
                status_d = swq_pkg::ST_NOTHING_DUE;
              end else begin
                state_d = S_SCAN_RD;
              end
            end
            swq_pkg::OP_ADD: begin
              key_d = {add_wake, req_i.priority_req};
              if (is_full) begin
                valid_d  = 1'b1;
                status_d = swq_pkg::ST_FULL;
              end else begin
                state_d = S_SCAN_RD;
              end
            end
            swq_pkg::OP_REMOVE: begin
              key_d   = {{(KW - swq_pkg::TASK_W){1'b0}}, req_i.task_id};
              state_d = S_SCAN_RD;
            end
            swq_pkg::OP_REQUEUE: begin
              key_d = {req_i.wake_tick, req_i.priority_req};
              if (is_full) begin
                valid_d  = 1'b1;
                status_d = swq_pkg::ST_FULL;
              end else begin
                pos_d   = '0;
                idx_d   = count_q;
                state_d = S_OPEN_RD;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_SCAN_RD: begin
        if (idx_q == count_q) begin
          if (op_q == swq_pkg::OP_ADD) begin
            pos_d   = idx_q;
            state_d = S_OPEN_RD;
          end else begin
            valid_d  = 1'b1;
            status_d = swq_pkg::ST_NOT_FOUND;
            state_d  = S_IDLE;
          end
        end else begin
          state_d = S_SCAN_EV;
        end
      end

      S_SCAN_EV: begin
        unique case (op_q)
          swq_pkg::OP_POLL: begin
            if (!cmp_gt) begin
              woke_task_d = rd_entry.task_id;
              woke_wake_d = rd_entry.wake;
              pos_d       = '0;
              state_d     = S_CLOSE_RD;
            end else begin
              valid_d  = 1'b1;
              status_d = swq_pkg::ST_NOTHING_DUE;
              state_d  = S_IDLE;
            end
          end
          swq_pkg::OP_REMOVE: begin
            if (cmp_eq) begin
              pos_d   = idx_q;
              state_d = S_CLOSE_RD;
            end else begin
              idx_d   = idx_inc;
              state_d = S_SCAN_RD;
            end
          end
          swq_pkg::OP_ADD, swq_pkg::OP_REQUEUE: begin
            // Insert after every entry whose key is not greater than the new one.
            if (cmp_gt) begin
              pos_d   = idx_q;
              idx_d   = count_q;
              state_d = S_OPEN_RD;
            end else begin
              idx_d   = idx_inc;
              state_d = S_SCAN_RD;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end

      S_OPEN_RD: begin
        if (idx_q == pos_q) begin
          ram_we    = 1'b1;
          ram_wdata = '{wake: key_q[KW-1:PW], task_id: task_q, prio: key_q[PW-1:0]};
          count_d   = count_q + CNT_W'(1);
          valid_d   = 1'b1;
          status_d  = swq_pkg::ST_QUEUED;
          state_d   = S_IDLE;
        end else begin
          ram_raddr = idx_dec[ADDR_W-1:0];
          state_d   = S_OPEN_WR;
        end
      end

      S_OPEN_WR: begin
        ram_we  = 1'b1;
        idx_d   = idx_dec;
        state_d = S_OPEN_RD;
      end

      S_CLOSE_RD: begin
        if (idx_inc >= count_q) begin
          count_d  = count_q - CNT_W'(1);
          valid_d  = 1'b1;
          status_d = (op_q == swq_pkg::OP_POLL) ? swq_pkg::ST_WOKEN : swq_pkg::ST_REMOVED;
          state_d  = S_IDLE;
        end else begin
          ram_raddr = idx_inc[ADDR_W-1:0];
          state_d   = S_CLOSE_WR;
        end
      end

      S_CLOSE_WR: begin
        ram_we  = 1'b1;
        idx_d   = idx_inc;
        state_d = S_CLOSE_RD;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    pos_q       <= pos_d;
    op_q        <= op_d;
    key_q       <= key_d;
    task_q      <= task_d;
    woke_task_q <= woke_task_d;
    woke_wake_q <= woke_wake_d;
    status_q    <= status_d;
  end

  assign occ_ext = {{swq_pkg::OCC_W{1'b0}}, count_q};

  assign busy_o  = (state_q != S_IDLE);
  assign valid_o = valid_q;

  always_comb begin
    rsp_o.status        = status_q;
    rsp_o.out_task      = (status_q == swq_pkg::ST_WOKEN) ? woke_task_q : '0;
    rsp_o.out_wake_tick = (status_q == swq_pkg::ST_WOKEN) ? woke_wake_q : '0;
    rsp_o.occupancy     = occ_ext[swq_pkg::OCC_W-1:0];
  end

endmodule

### sv/swq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module swq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/swq_cmp.sv
// Shared key comparator: greater-than and equality on a wake tick and priority key, or on a task identifier.
module swq_cmp (
  input  logic [swq_pkg::KEY_W-1:0] a_i,
  input  logic [swq_pkg::KEY_W-1:0] b_i,
  output logic                      gt_o,
  output logic                      eq_o
);

  assign gt_o = (a_i > b_i);
  assign eq_o = (a_i == b_i);

endmodule

### sv/swq_chk.sv
// Port-level checker for the sleep queue, bound to the top level.
`include "assert_macros.svh"

module swq_chk (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start_i,
  input logic          busy_o,
  input logic          valid_o,
  input swq_pkg::rsp_t rsp_o
);

  // An accepted transaction either answers at once or keeps the block busy.
  `SWQ_ASSERT(a_accept_progress, (start_i && !busy_o) |=> (busy_o || valid_o), "accepted transaction dropped")

  // A result is never shown while the block is still working.
  `SWQ_ASSERT_NEVER(a_no_result_busy, valid_o && busy_o, "result shown while busy")

  // Every result follows an accepted transaction or a busy period.
  `SWQ_ASSERT(a_no_spurious, valid_o |-> ($past(busy_o) || ($past(start_i) && !$past(busy_o))), "result without transaction")

  // Only a woken task carries an identifier and wake tick.
  `SWQ_ASSERT(a_zero_fields, (valid_o && (rsp_o.status != swq_pkg::ST_WOKEN)) |-> ((rsp_o.out_task == '0) && (rsp_o.out_wake_tick == '0)), "stale task fields")

endmodule

bind sleep_wake_queue swq_chk u_swq_chk (.*);

### tb/sv/tb_top.sv
// Self-checking testbench of the sleep queue, with its own model of the sorted queue.
module tb_top;

  localparam int CAPACITY    = swq_pkg::QUEUE_DEPTH_DEF;
  localparam int OCC_W       = swq_pkg::OCC_W;
  localparam int RAND_CALLS  = 1400;
  localparam int CYCLE_LIMIT = 400_000;
  localparam int DRAIN_WAIT  = 2 * CAPACITY + 8;

  typedef struct {
    swq_pkg::req_t req;
    int unsigned   gap;
  } call_t;

  logic           clk_i     = 1'b0;
  logic           rst_ni    = 1'b0;
  logic           start_i   = 1'b0;
  swq_pkg::req_t  req_i     = '0;
  logic           busy_o;
  logic           valid_o;
  swq_pkg::rsp_t  rsp_o;

  call_t           call_q[$];
  swq_pkg::rsp_t   pending_rsp_q[$];
  swq_pkg::entry_t sleepers[$];
  int unsigned     err_count = 0;
  int unsigned     idle_count = 0;
  int unsigned     cycle_count = 0;

  sleep_wake_queue u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .req_i   (req_i),
    .busy_o  (busy_o),
    .valid_o (valid_o),
    .rsp_o   (rsp_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string msg);
    err_count++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is 0x%0h, 0x%0h expected", name, got, want));
  endtask

  // Applies one transaction to the shadow queue and returns the response it calls for.
  function automatic swq_pkg::rsp_t sleep_queue_apply(swq_pkg::req_t r);
    swq_pkg::rsp_t   res;
    swq_pkg::entry_t fresh;
    logic [31:0]     wake;
    int              pos;
    res = '0;
    res.status = swq_pkg::ST_NOTHING_DUE;
    case (r.op)
      swq_pkg::OP_POLL: begin
        if (sleepers.size() > 0 && r.now >= sleepers[0].wake) begin
          res.status        = swq_pkg::ST_WOKEN;
          res.out_task      = sleepers[0].task_id;
          res.out_wake_tick = sleepers[0].wake;
          void'(sleepers.pop_front());
        end
      end
      swq_pkg::OP_ADD: begin
        if (sleepers.size() >= CAPACITY) begin
          res.status = swq_pkg::ST_FULL;
        end else begin
          wake = r.now + r.delay;
          pos  = 0;
          // Skip every entry that wakes earlier, or at the same tick with no larger priority.
          while (pos < sleepers.size() && (sleepers[pos].wake < wake ||
                 (sleepers[pos].wake == wake && sleepers[pos].prio <= r.priority_req)))
            pos++;
          fresh.wake    = wake;
          fresh.task_id = r.task_id;
          fresh.prio    = r.priority_req;
          sleepers.insert(pos, fresh);
          res.status = swq_pkg::ST_QUEUED;
        end
      end
      swq_pkg::OP_REMOVE: begin
        res.status = swq_pkg::ST_NOT_FOUND;
        for (pos = 0; pos < sleepers.size(); pos++) begin
          if (sleepers[pos].task_id == r.task_id) begin
            sleepers.delete(pos);
            res.status = swq_pkg::ST_REMOVED;
            break;
          end
        end
      end
      default: begin
        if (sleepers.size() >= CAPACITY) begin
          res.status = swq_pkg::ST_FULL;
        end else begin
          fresh.wake    = r.wake_tick;
          fresh.task_id = r.task_id;
          fresh.prio    = r.priority_req;
          sleepers.push_front(fresh);
          res.status = swq_pkg::ST_QUEUED;
        end
      end
    endcase
    res.occupancy = OCC_W'(sleepers.size());
    return res;
  endfunction

  function automatic swq_pkg::req_t make_call(swq_pkg::op_e op, logic [7:0] tid,
                                              logic [31:0] delay, logic [7:0] prio,
                                              logic [31:0] now, logic [31:0] wake);
    swq_pkg::req_t r;
    r.op           = op;
    r.task_id      = tid;
    r.delay        = delay;
    r.priority_req = prio;
    r.now          = now;
    r.wake_tick    = wake;
    return r;
  endfunction

  task automatic queue_call(swq_pkg::req_t r, int unsigned gap);
    call_t c;
    c.req = r;
    c.gap = gap;
    call_q.push_back(c);
  endtask

  // Driver: presents one transaction at a time, with the number of idle cycles given by each call before it.
  always @(posedge clk_i) begin
    logic free;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      free = !start_i;
      if (start_i && !busy_o) begin
        pending_rsp_q.push_back(sleep_queue_apply(req_i));
        free = 1'b1;
      end
      if (free) begin
        if (call_q.size() == 0) begin
          start_i <= 1'b0;
        end else if (idle_count < call_q[0].gap) begin
          idle_count++;
          start_i <= 1'b0;
        end else begin
          req_i      <= call_q[0].req;
          start_i    <= 1'b1;
          idle_count = 0;
          void'(call_q.pop_front());
        end
      end
    end
  end

  // Monitor: every result strobe is matched against the oldest outstanding response.
  always @(posedge clk_i) begin
    swq_pkg::rsp_t want;
    if (rst_ni && valid_o) begin
      if (pending_rsp_q.size() == 0) begin
        report_mismatch("result seen with no transaction outstanding");
      end else begin
        want = pending_rsp_q.pop_front();
        check_field("status", 32'(rsp_o.status), 32'(want.status));
        check_field("out_task", 32'(rsp_o.out_task), 32'(want.out_task));
        check_field("out_wake_tick", rsp_o.out_wake_tick, want.out_wake_tick);
        check_field("occupancy", 32'(rsp_o.occupancy), 32'(want.occupancy));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    swq_pkg::req_t r;
    logic [31:0]   sys_tick;
    int unsigned   roll;
    int unsigned   phase;
    logic          no_idle;
    int unsigned   gap;

    // Directed part: empty queue, absent id, wrapped wake tick, ties, duplicates, full queue.
    queue_call(make_call(swq_pkg::OP_POLL, 8'h00, 32'h0, 8'h00, 32'hFFFF_FFFF, 32'h0), 0);
    queue_call(make_call(swq_pkg::OP_REMOVE, 8'hFF, 32'h0, 8'h00, 32'h0, 32'h0), 3);
    queue_call(make_call(swq_pkg::OP_ADD, 8'h01, 32'h0, 8'h00, 32'h0, 32'h0), 0);
    queue_call(make_call(swq_pkg::OP_ADD, 8'hFF, 32'h2, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
               1);
    queue_call(make_call(swq_pkg::OP_ADD, 8'h02, 32'h0, 8'h00, 32'h0, 32'h0), 0);
    queue_call(make_call(swq_pkg::OP_ADD, 8'h03, 32'h0, 8'h80, 32'h0, 32'h0), 16);
    queue_call(make_call(swq_pkg::OP_REQUEUE, 8'h05, 32'h0, 8'hAA, 32'h0, 32'hFFFF_FFFF), 0);
    queue_call(make_call(swq_pkg::OP_POLL, 8'h00, 32'h0, 8'h00, 32'h0, 32'h0), 2);
    queue_call(make_call(swq_pkg::OP_POLL, 8'h00, 32'h0, 8'h00, 32'hFFFF_FFFF, 32'h0), 0);
    queue_call(make_call(swq_pkg::OP_ADD, 8'h02, 32'hFFFF_FFFF, 8'h7F, 32'h1, 32'h0), 5);
    queue_call(make_call(swq_pkg::OP_REMOVE, 8'h02, 32'h0, 8'h00, 32'h0, 32'h0), 0);
    queue_call(make_call(swq_pkg::OP_POLL, 8'h00, 32'h0, 8'h00, 32'h0, 32'h0), 0);
    for (int i = 0; i < 13; i++) begin
      if (i == 0)
        r = make_call(swq_pkg::OP_ADD, 8'h40, 32'hFFFF_FFFF, 8'h00, 32'hFFFF_FFFF, 32'h0);
      else
        r = make_call(swq_pkg::OP_ADD, 8'($urandom_range(0, 255)), $urandom,
                      8'($urandom_range(0, 255)), $urandom, $urandom);
      queue_call(r, $urandom_range(0, 2));
    end
    queue_call(make_call(swq_pkg::OP_ADD, 8'h77, 32'h10, 8'h01, 32'h0, 32'h0), 0);
    queue_call(make_call(swq_pkg::OP_REQUEUE, 8'h78, 32'h0, 8'h01, 32'h0, 32'h5), 0);

    // Random part. The tick starts close to the top so that it wraps during the run.
    sys_tick = 32'hFFFF_F000 + $urandom_range(0, 255);
    phase    = 0;
    no_idle  = 1'b0;
    for (int i = 0; i < RAND_CALLS; i++) begin
      if (i % 60 == 0) begin
        phase   = $urandom_range(0, 2);
        no_idle = ($urandom_range(0, 3) == 0);
      end
      sys_tick += $urandom_range(0, 20);
      if (phase == 1 && $urandom_range(0, 9) == 0) sys_tick += $urandom_range(200, 2000);
      roll = $urandom_range(0, 99);
      // Inputs that an operation ignores still carry random values.
      r = make_call(swq_pkg::OP_POLL, 8'($urandom), $urandom, 8'($urandom), $urandom,
                    $urandom);
      case (phase)
        0:       r.op = roll < 60 ? swq_pkg::OP_ADD : roll < 75 ? swq_pkg::OP_POLL :
                        roll < 90 ? swq_pkg::OP_REMOVE : swq_pkg::OP_REQUEUE;
        1:       r.op = roll < 60 ? swq_pkg::OP_POLL : roll < 75 ? swq_pkg::OP_ADD :
                        roll < 95 ? swq_pkg::OP_REMOVE : swq_pkg::OP_REQUEUE;
        default: r.op = roll < 35 ? swq_pkg::OP_ADD : roll < 70 ? swq_pkg::OP_POLL :
                        roll < 88 ? swq_pkg::OP_REMOVE : swq_pkg::OP_REQUEUE;
      endcase
      if ($urandom_range(0, 3) != 0) r.task_id = 8'($urandom_range(0, 23));
      if ($urandom_range(0, 9) < 7) r.priority_req = 8'($urandom_range(0, 3));
      if ($urandom_range(0, 6) != 0) r.now = sys_tick;
      roll = $urandom_range(0, 9);
      if (roll < 8)
        r.delay = $urandom_range(0, 200);
      else if (roll == 8)
        r.delay = 32'hFFFF_FFFF - $urandom_range(0, 50);
      if ($urandom_range(0, 1) == 0) r.wake_tick = sys_tick + $urandom_range(0, 100);
      gap = no_idle ? 0 : $urandom_range(0, 16);
      queue_call(r, gap);
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (call_q.size() != 0 || start_i || pending_rsp_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (err_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
